>>> hdl/settled_sample_averager_defines.svh
// ----------------------------------------------------------------------------
// settled_sample_averager_defines
// Assertion macros shared by the settled sample averager modules.
// ----------------------------------------------------------------------------
`ifndef SETTLED_SAMPLE_AVERAGER_DEFINES_SVH
`define SETTLED_SAMPLE_AVERAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int unsigned RAW_W  = 16;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned SUM_W  = 23;
    localparam int unsigned AVG_W  = 15;
    localparam int unsigned STL_W  = 2;

    localparam int unsigned SETTLE_READS_DEF = 2;
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 8'd8;

    localparam logic [RAW_W-1:0] REJECT_LIMIT = 16'h7FFF;
    localparam logic [AVG_W-1:0] AVG_MAX      = 15'd32766;

    // One quotient bit per step of the restoring divider.
    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic ld_item;   // accept an input item into the burst state
        logic div_step;  // advance the divider by one quotient bit
        logic ld_out;    // load the saturated quotient into the output register
    } t_cmd;

    typedef struct packed {
        logic ends_burst; // the offered item closes the current burst
    } t_sts;

endpackage

>>> hdl/ssa_dp.sv
// ----------------------------------------------------------------------------
// ssa_dp
// Burst state, accumulator, configuration register and serial divider.
// ----------------------------------------------------------------------------
`include "settled_sample_averager_defines.svh"

module ssa_dp #(
    parameter int unsigned SETTLE_READS = ssa_pkg::SETTLE_READS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [ssa_pkg::CNT_W-1:0] i_cfg_sample_count,
    input  logic [ssa_pkg::RAW_W-1:0] i_raw_sample,
    input  logic                      i_start_req,
    input  ssa_pkg::t_cmd             i_cmd,
    output ssa_pkg::t_sts             o_sts,
    output logic [ssa_pkg::AVG_W-1:0] o_average
);
    import ssa_pkg::*;

    logic [CNT_W-1:0] r_sample_count;
    logic             r_in_burst, n_in_burst;
    logic [STL_W-1:0] r_settle, n_settle;
    logic [CNT_W-1:0] r_taken, n_taken;
    logic [SUM_W-1:0] r_sum, n_sum;

    logic [SUM_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_den;
    logic [AVG_W-1:0] r_average;

    // Effective burst state after a possible start
    logic             eff_in_burst;
    logic [STL_W-1:0] eff_settle;
    logic [CNT_W-1:0] eff_taken;
    logic [SUM_W-1:0] eff_sum;
    logic [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0] acc_taken;
    logic [CNT_W-1:0] count;
    logic             counting;
    logic             ends;

    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    always_comb begin
        count        = (r_sample_count == '0) ? CNT_W'(1) : r_sample_count;
        eff_in_burst = i_start_req | r_in_burst;
        eff_settle   = i_start_req ? STL_W'(SETTLE_READS) : r_settle;
        eff_taken    = i_start_req ? '0 : r_taken;
        eff_sum      = i_start_req ? '0 : r_sum;
        acc_sum      = (i_raw_sample < REJECT_LIMIT)
                     ? eff_sum + SUM_W'(i_raw_sample) : eff_sum;
        acc_taken    = eff_taken + CNT_W'(1);
        counting     = eff_in_burst && (eff_settle == '0);
        ends         = counting && (acc_taken >= count);
        o_sts.ends_burst = ends;
    end

    always_comb begin
        n_in_burst = r_in_burst;
        n_settle   = r_settle;
        n_taken    = r_taken;
        n_sum      = r_sum;
        if (i_cmd.ld_item && eff_in_burst) begin
            n_in_burst = 1'b1;
            n_taken    = eff_taken;
            n_sum      = eff_sum;
            n_settle   = eff_settle;
            if (eff_settle != '0) begin
                n_settle = eff_settle - STL_W'(1);
            end else if (ends) begin
                n_in_burst = 1'b0;
                n_taken    = '0;
                n_sum      = '0;
            end else begin
                n_taken = acc_taken;
                n_sum   = acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
            r_in_burst     <= 1'b0;
            r_settle       <= '0;
            r_taken        <= '0;
            r_sum          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sample_count <= i_cfg_sample_count;
            end
            r_in_burst <= n_in_burst;
            r_settle   <= n_settle;
            r_taken    <= n_taken;
            r_sum      <= n_sum;
        end
    end

    // Restoring division, one quotient bit per step
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        n_quo = {r_quo[SUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item && ends) begin
            r_quo <= acc_sum;
            r_rem <= '0;
            r_den <= count;
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.ld_out) begin
            r_average <= (r_quo > SUM_W'(AVG_MAX)) ? AVG_MAX : r_quo[AVG_W-1:0];
        end
    end

    assign o_average = r_average;

    `SSA_ASSERT_IMPLY(a_rem_below_den, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_den, "divider remainder out of range")
    `SSA_ASSERT_IMPLY(a_idle_clear, i_clk, i_rst_n, !r_in_burst, (r_taken == '0) && (r_sum == '0), "stale burst state outside a burst")
    `SSA_ASSERT_NEXT(a_avg_sat, i_clk, i_rst_n, i_cmd.ld_out, r_average <= AVG_MAX, "average above saturation limit")

endmodule

>>> hdl/ssa_ctrl.sv
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer for item intake, serial division and result hand-off.
// ----------------------------------------------------------------------------
`include "settled_sample_averager_defines.svh"

module ssa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ssa_pkg::t_sts i_sts,
    output ssa_pkg::t_cmd o_cmd
);
    import ssa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer;
    logic              out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.ld_item = in_xfer;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (in_xfer && i_sts.ends_burst) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.ld_out || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SSA_ASSERT_NEXT(a_end_starts_div, i_clk, i_rst_n, in_xfer && i_sts.ends_burst, r_state == ST_DIV, "burst end did not start division")
    `SSA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid, "stalled result dropped")
    `SSA_ASSERT_IMPLY(a_step_range, i_clk, i_rst_n, r_state == ST_DIV, r_step < STEP_W'(DIV_STEPS), "divider step count overrun")
    `SSA_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, o_cmd.ld_out, out_free, "result loaded over a pending one")

endmodule

>>> hdl/settled_sample_averager.sv
// ----------------------------------------------------------------------------
// settled_sample_averager
// Burst averager: drop settling reads, sum in-range reads, divide by count.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one converter word per transfer,
// with i_start_req marking the first word of a burst. The first SETTLE_READS
// words of a burst are dropped, the next sample_count words are counted and
// only words below 0x7FFF are summed. Words outside a burst are ignored.
// Output channel (o_out_valid / i_out_stall): one average per burst, the sum
// divided by sample_count (1 if zero), truncated and saturated at 32766.
// Config channel (i_cfg_valid / o_cfg_ready): writes sample_count; always
// ready. Write it only while the block is idle.
// A word that does not close a burst is taken without a stall. The word
// that closes a burst starts a restoring divider that yields one quotient
// bit per cycle, then the output register is loaded with the result; the
// input stalls while the division runs and until that load. If the receiver
// stalls, the result is held in the output register; further words are
// taken until another division finishes, which then waits for the
// register to drain. Reset clears the burst state, drops any pending
// result and sets sample_count to 8.
// ----------------------------------------------------------------------------
module settled_sample_averager #(
    parameter int unsigned SETTLE_READS = ssa_pkg::SETTLE_READS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ssa_pkg::CNT_W-1:0] i_cfg_sample_count,
    // input words
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ssa_pkg::RAW_W-1:0] i_raw_sample,
    input  logic                      i_start_req,
    // averages
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [ssa_pkg::AVG_W-1:0] o_average
);
    import ssa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The register is a plain flop, so every write transfer completes at once.
    assign o_cfg_ready = 1'b1;

    ssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ssa_dp #(
        .SETTLE_READS (SETTLE_READS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_sample_count (i_cfg_sample_count),
        .i_raw_sample       (i_raw_sample),
        .i_start_req        (i_start_req),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_average          (o_average)
    );

endmodule
